### hw/rtl/uas_pkg.sv
// ----------------------------------------------------------------------------
// uas_pkg
// Shared sizes, register codes and types for the upwind advection step.
// ----------------------------------------------------------------------------
package uas_pkg;

    // Grid and value sizes.
    localparam int MAX_COLS   = 1024;
    localparam int COL_BITS   = $clog2(MAX_COLS);
    localparam int LEN_BITS   = COL_BITS + 1;
    localparam int VALUE_BITS = 16;
    localparam int COEF_BITS  = 16;

    // Register file layout.
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    typedef enum logic [1:0] {
        REG_Y_COEF         = 2'd0,
        REG_COLS_IN_USE    = 2'd1,
        REG_BOUNDARY_VALUE = 2'd2
    } reg_index_t;

    localparam logic [LEN_BITS-1:0] COLS_RESET = LEN_BITS'(MAX_COLS);

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [COEF_BITS-1:0]         y_coef;
        logic [LEN_BITS-1:0]          cols_in_use;
        logic signed [VALUE_BITS-1:0] boundary_value;
    } cfg_t;

endpackage

### hw/rtl/uas_regs.sv
// ----------------------------------------------------------------------------
// uas_regs
// APB register file holding the y coefficient, row length and boundary value.
// ----------------------------------------------------------------------------
module uas_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [uas_pkg::ADDR_BITS-1:0] paddr,
    input  logic [uas_pkg::DATA_BITS-1:0] pwdata,
    output logic [uas_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    output uas_pkg::cfg_t                 cfg
);

    uas_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.y_coef         <= '0;
            cfg_reg.cols_in_use    <= uas_pkg::COLS_RESET;
            cfg_reg.boundary_value <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                uas_pkg::REG_Y_COEF:
                    cfg_reg.y_coef <= pwdata[uas_pkg::COEF_BITS-1:0];
                uas_pkg::REG_COLS_IN_USE:
                    cfg_reg.cols_in_use <= pwdata[uas_pkg::LEN_BITS-1:0];
                uas_pkg::REG_BOUNDARY_VALUE:
                    cfg_reg.boundary_value <= pwdata[uas_pkg::VALUE_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        case (reg_sel)
            uas_pkg::REG_Y_COEF:
                prdata = uas_pkg::DATA_BITS'(cfg_reg.y_coef);
            uas_pkg::REG_COLS_IN_USE:
                prdata = uas_pkg::DATA_BITS'(cfg_reg.cols_in_use);
            uas_pkg::REG_BOUNDARY_VALUE:
                prdata = uas_pkg::DATA_BITS'($unsigned(cfg_reg.boundary_value));
            default:
                prdata = '0;
        endcase
    end

endmodule

### hw/rtl/upwind_advection_step.sv
// ----------------------------------------------------------------------------
// upwind_advection_step
// One explicit time step of first-order upwind 2D advection over a raster
// stream of interior cells.
// ----------------------------------------------------------------------------
// The block takes one cell word per cycle while in_stall is low and returns
// one result word per cell, in order. Each cell passes through stage one,
// stage two and stage three in turn. Stage one registers the cell and reads
// the previous row's value from a 1024-entry line store (one read and one
// write per accepted cell); stage two forms the two coefficient products;
// stage three sums, rounds half up and saturates into the output register.
// A stall on the output holds the pipeline, and bubbles in it still let new
// cells enter.
module upwind_advection_step (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Cell input channel.
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [uas_pkg::VALUE_BITS-1:0] cell_value,
    input  logic [uas_pkg::COEF_BITS-1:0]        x_coef,
    input  logic                                 start_of_sweep,
    // Result output channel.
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [uas_pkg::VALUE_BITS-1:0] new_value,
    output logic                                 clipped,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [uas_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [uas_pkg::DATA_BITS-1:0]        pwdata,
    output logic [uas_pkg::DATA_BITS-1:0]        prdata,
    output logic                                 pready
);

    localparam int VB   = uas_pkg::VALUE_BITS;
    localparam int CB   = uas_pkg::COL_BITS;
    localparam int LB   = uas_pkg::LEN_BITS;
    localparam int DB   = VB + 1;
    localparam int PB   = DB + uas_pkg::COEF_BITS + 1;
    localparam int AB   = PB + 2;
    localparam int FRAC = uas_pkg::COEF_BITS;
    localparam int RB   = AB - FRAC;

    localparam logic signed [RB-1:0] VMAX = RB'((2 ** (VB - 1)) - 1);
    localparam logic signed [RB-1:0] VMIN = -VMAX - RB'(1);

    uas_pkg::cfg_t cfg;

    logic accept;
    logic ld1;
    logic ld2;
    logic ld3;

    // Sweep position state.
    logic [CB-1:0]          col_index_reg;
    logic [CB-1:0]          col_index_next;
    logic                   first_row_reg;
    logic                   first_row_next;
    logic signed [VB-1:0]   prev_cell_reg;
    logic [CB-1:0]          col_cur;
    logic                   first_cur;
    logic [LB-1:0]          len_eff;
    logic [LB-1:0]          col_inc;

    // Line store.
    logic signed [VB-1:0]   row_store [uas_pkg::MAX_COLS];
    logic signed [VB-1:0]   up_rd_reg;

    // Stage one.
    logic                   s1_valid_reg;
    logic signed [VB-1:0]   s1_u_reg;
    logic [uas_pkg::COEF_BITS-1:0] s1_cx_reg;
    logic signed [VB-1:0]   s1_left_reg;
    logic                   s1_first_reg;
    logic signed [VB-1:0]   s1_up;
    logic signed [DB-1:0]   s1_dx;
    logic signed [DB-1:0]   s1_dy;
    logic signed [PB-1:0]   s1_px;
    logic signed [PB-1:0]   s1_py;

    // Stage two.
    logic                   s2_valid_reg;
    logic signed [VB-1:0]   s2_u_reg;
    logic signed [PB-1:0]   s2_px_reg;
    logic signed [PB-1:0]   s2_py_reg;
    logic signed [AB-1:0]   s2_acc;
    logic signed [RB-1:0]   s2_round;
    logic signed [VB-1:0]   s2_sat;
    logic                   s2_clip;

    // Output register.
    logic                   out_valid_reg;
    logic signed [VB-1:0]   new_value_reg;
    logic                   clipped_reg;

    uas_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pipeline advance: each stage loads when the one after it can take its word.
    assign ld3      = !out_valid_reg || !out_stall;
    assign ld2      = !s2_valid_reg || ld3;
    assign ld1      = !s1_valid_reg || ld2;
    assign in_stall = !ld1;
    assign accept   = in_valid && ld1;

    // Row length clamped to the range the line store supports.
    always_comb
    begin
        if (cfg.cols_in_use == '0)
        begin
            len_eff = LB'(1);
        end
        else if (cfg.cols_in_use > uas_pkg::COLS_RESET)
        begin
            len_eff = uas_pkg::COLS_RESET;
        end
        else
        begin
            len_eff = cfg.cols_in_use;
        end
    end

    // Position of the arriving cell and the position after it.
    always_comb
    begin
        col_cur   = start_of_sweep ? '0 : col_index_reg;
        first_cur = start_of_sweep || first_row_reg;
        col_inc   = {1'b0, col_cur} + LB'(1);
        if (col_inc >= len_eff)
        begin
            col_index_next = '0;
            first_row_next = 1'b0;
        end
        else
        begin
            col_index_next = col_inc[CB-1:0];
            first_row_next = first_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_index_reg <= '0;
            first_row_reg <= 1'b1;
            prev_cell_reg <= '0;
        end
        else if (accept)
        begin
            col_index_reg <= col_index_next;
            first_row_reg <= first_row_next;
            prev_cell_reg <= cell_value;
        end
    end

    // Line store: the old value is read before this cell overwrites it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg          <= row_store[col_cur];
            row_store[col_cur] <= cell_value;
        end
    end

    // Stage one registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (ld1)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_u_reg     <= cell_value;
            s1_cx_reg    <= x_coef;
            s1_left_reg  <= (col_cur == '0) ? cfg.boundary_value : prev_cell_reg;
            s1_first_reg <= first_cur;
        end
    end

    // Differences to the neighbors and the two coefficient products.
    always_comb
    begin
        s1_up = s1_first_reg ? cfg.boundary_value : up_rd_reg;
        s1_dx = DB'(s1_u_reg) - DB'(s1_up);
        s1_dy = DB'(s1_u_reg) - DB'(s1_left_reg);
        s1_px = PB'($signed({1'b0, s1_cx_reg})) * PB'(s1_dx);
        s1_py = PB'($signed({1'b0, cfg.y_coef})) * PB'(s1_dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (ld2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_u_reg  <= s1_u_reg;
            s2_px_reg <= s1_px;
            s2_py_reg <= s1_py;
        end
    end

    // Sum, round half up to the value grid, then saturate.
    always_comb
    begin
        s2_acc   = (AB'(s2_u_reg) <<< FRAC) - AB'(s2_px_reg) - AB'(s2_py_reg)
                   + AB'(2 ** (FRAC - 1));
        s2_round = s2_acc[AB-1:FRAC];
        if (s2_round > VMAX)
        begin
            s2_sat  = VMAX[VB-1:0];
            s2_clip = 1'b1;
        end
        else if (s2_round < VMIN)
        begin
            s2_sat  = VMIN[VB-1:0];
            s2_clip = 1'b1;
        end
        else
        begin
            s2_sat  = s2_round[VB-1:0];
            s2_clip = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ld3)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            new_value_reg <= s2_sat;
            clipped_reg   <= s2_clip;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_value = new_value_reg;
    assign clipped   = clipped_reg;

    // A clipped result sits at one of the two range limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> new_value == VMAX[VB-1:0] || new_value == VMIN[VB-1:0])
        else $error("clipped result is not at a range limit");

    // A start of sweep on a row longer than one cell leaves the sweep in its first row.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && start_of_sweep && len_eff != LB'(1) |=> first_row_reg)
        else $error("start of sweep did not select the first row");

    // The first cell of a sweep sees the boundary to its left.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && start_of_sweep |=> s1_left_reg == $past(cfg.boundary_value))
        else $error("first cell of sweep did not use the boundary on its left");

    // An empty first stage never holds off the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with an empty first stage");

endmodule

### tb/sv/upwind_step_checker.sv
// ----------------------------------------------------------------------------
// upwind_step_checker
// Watches the cell and result channels of the upwind advection step, works
// out each expected result word and compares it with what comes out.
// ----------------------------------------------------------------------------
// Register writes are picked up from the configuration port, so the checker
// keeps its own copy of the settings. Every accepted cell word is advected
// with a private copy of the line store, the left neighbor and the raster
// position. Result words are compared in order, field by field.
module upwind_step_checker import uas_pkg::*; (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [VALUE_BITS-1:0] cell_value,
    input  logic [COEF_BITS-1:0]         x_coef,
    input  logic                         start_of_sweep,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic signed [VALUE_BITS-1:0] new_value,
    input  logic                         clipped,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [ADDR_BITS-1:0]         paddr,
    input  logic [DATA_BITS-1:0]         pwdata,
    output int                           mismatches,
    output int                           outstanding,
    output int                           checked,
    output int                           saturated
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint VMAX = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic                         clip;
    } cell_update_t;

    // Updated cells waiting for their result word.
    cell_update_t updated_cells_q[$];

    // Mirrored register settings.
    logic [COEF_BITS-1:0]         y_coef_r;
    logic [LEN_BITS-1:0]          cols_r;
    logic signed [VALUE_BITS-1:0] boundary_r;

    // Grid position and neighbor storage.
    logic signed [VALUE_BITS-1:0] line_store [MAX_COLS];
    logic signed [VALUE_BITS-1:0] left_old;
    int unsigned                  col;
    bit                           top_row;

    int err_total;
    int seen_total;
    int sat_total;

    // Effective row length: zero acts as one, oversize acts as the full store.
    function automatic int unsigned row_len(input logic [LEN_BITS-1:0] cols);
        if (cols == 0)
            return 1;
        if (cols > MAX_COLS)
            return MAX_COLS;
        return 32'(cols);
    endfunction

    // Advect one cell and queue its expected result word.
    task automatic advect_cell(input logic signed [VALUE_BITS-1:0] u_bits,
                               input logic [COEF_BITS-1:0] cx_bits,
                               input logic sweep);
        longint       u;
        longint       cx;
        longint       cy;
        longint       up;
        longint       left;
        longint       acc;
        longint       res;
        cell_update_t upd;
        u  = longint'(u_bits);
        cx = longint'(cx_bits);
        cy = longint'(y_coef_r);
        if (sweep) begin
            col     = 0;
            top_row = 1'b1;
        end
        if (col == 0)
            left = longint'(boundary_r);
        else
            left = longint'(left_old);
        if (top_row)
            up = longint'(boundary_r);
        else
            up = longint'(line_store[col]);

        // Exact sum in Q.16, then round half up back to the value grid.
        acc = u * (longint'(1) <<< COEF_BITS) - cx * (u - up) - cy * (u - left);
        res = (acc + (longint'(1) <<< (COEF_BITS - 1))) >>> COEF_BITS;
        upd.clip = 1'b0;
        if (res > VMAX) begin
            res      = VMAX;
            upd.clip = 1'b1;
        end
        else if (res < VMIN) begin
            res      = VMIN;
            upd.clip = 1'b1;
        end
        upd.value = res[VALUE_BITS-1:0];

        // Old values feed the next row and the next cell.
        line_store[col] = u_bits;
        left_old        = u_bits;
        col++;
        if (col >= row_len(cols_r)) begin
            col     = 0;
            top_row = 1'b0;
        end
        updated_cells_q.push_back(upd);
    endtask

    // Sample both channels and the configuration port at each edge.
    always @(posedge clk or negedge rst_n) begin
        cell_update_t want;
        if (!rst_n) begin
            y_coef_r   = '0;
            cols_r     = COLS_RESET;
            boundary_r = '0;
            left_old   = '0;
            col        = 0;
            top_row    = 1'b1;
            err_total  = 0;
            seen_total = 0;
            sat_total  = 0;
            updated_cells_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
            checked     <= 0;
            saturated   <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_index_t'(paddr[ADDR_BITS-1:2]))
                    REG_Y_COEF:         y_coef_r   = pwdata[COEF_BITS-1:0];
                    REG_COLS_IN_USE:    cols_r     = pwdata[LEN_BITS-1:0];
                    REG_BOUNDARY_VALUE: boundary_r = pwdata[VALUE_BITS-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                advect_cell(cell_value, x_coef, start_of_sweep);

            if (out_valid && !out_stall) begin
                if (updated_cells_q.size() == 0) begin
                    $display("%0t: result word %0d clipped=%0b arrived with no cell pending",
                             $time, new_value, clipped);
                    err_total++;
                end
                else begin
                    want = updated_cells_q.pop_front();
                    seen_total++;
                    if (clipped)
                        sat_total++;
                    if (new_value !== want.value) begin
                        $display("%0t: new_value expected %0d, got %0d",
                                 $time, $signed(want.value), new_value);
                        err_total++;
                    end
                    if (clipped !== want.clip) begin
                        $display("%0t: clipped expected %0b, got %0b",
                                 $time, want.clip, clipped);
                        err_total++;
                    end
                end
            end

            mismatches  <= err_total;
            outstanding <= updated_cells_q.size();
            checked     <= seen_total;
            saturated   <= sat_total;
        end
    end

endmodule

### tb/sv/upwind_advection_step_tb.sv
// ----------------------------------------------------------------------------
// upwind_advection_step_tb
// Streams raster sweeps of grid cells through the upwind advection step and
// lets the checker compare every result word.
// ----------------------------------------------------------------------------
// A short directed run covers the value and coefficient extremes, saturation,
// sweep restarts and odd row lengths. Random phases follow, each with its own
// register settings and a per-column coefficient table, so that most words
// form proper raster sweeps. The sender and the receiver idle in turn.
module upwind_advection_step_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import uas_pkg::*;

    localparam int NUM_PHASES     = 24;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic signed [VALUE_BITS-1:0] cell_value;
    logic [COEF_BITS-1:0]         x_coef;
    logic                         start_of_sweep;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [VALUE_BITS-1:0] new_value;
    logic                         clipped;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [ADDR_BITS-1:0]         paddr;
    logic [DATA_BITS-1:0]         pwdata;
    logic [DATA_BITS-1:0]         prdata;
    logic                         pready;

    int mismatches;
    int outstanding;
    int checked;
    int saturated;

    // Stimulus bookkeeping.
    int                   send_gap_pct = 6;
    int                   stall_pct    = 70;
    int unsigned          cur_len      = MAX_COLS;
    int unsigned          col_pos      = 0;
    bit                   sweep_due    = 1'b0;
    int                   cells_sent   = 0;
    int                   settings_cnt = 0;
    int                   quiet_cycles = 0;
    logic [COEF_BITS-1:0] column_coef [MAX_COLS];

    upwind_advection_step u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cell_value     (cell_value),
        .x_coef         (x_coef),
        .start_of_sweep (start_of_sweep),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .new_value      (new_value),
        .clipped        (clipped),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    upwind_step_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cell_value     (cell_value),
        .x_coef         (x_coef),
        .start_of_sweep (start_of_sweep),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .new_value      (new_value),
        .clipped        (clipped),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .checked        (checked),
        .saturated      (saturated)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // End the run if no word moves on either channel for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One register write: setup cycle, access cycle, then a released cycle.
    task automatic write_reg(input reg_index_t idx, input logic [DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(4 * int'(idx));
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write all three registers. A longer row forces a fresh sweep so that
    // no line store entry is read before it has been written.
    task automatic program_grid(input logic [COEF_BITS-1:0] y,
                                input logic [LEN_BITS-1:0] cols,
                                input logic signed [VALUE_BITS-1:0] bnd);
        int unsigned n;
        write_reg(REG_Y_COEF, DATA_BITS'(y));
        write_reg(REG_COLS_IN_USE, DATA_BITS'(cols));
        write_reg(REG_BOUNDARY_VALUE, DATA_BITS'(bnd));
        n = 32'(cols);
        if (n == 0)
            n = 1;
        if (n > MAX_COLS)
            n = MAX_COLS;
        if (n > cur_len)
            sweep_due = 1'b1;
        cur_len = n;
        settings_cnt++;
    endtask

    // Hand one cell word to the block, with a random gap in front of it.
    task automatic send_cell(input logic signed [VALUE_BITS-1:0] value,
                             input logic [COEF_BITS-1:0] coef,
                             input logic sos);
        logic mark;
        mark = sos || sweep_due;
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        cell_value     <= value;
        x_coef         <= coef;
        start_of_sweep <= mark;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        cells_sent++;
        sweep_due = 1'b0;
        col_pos   = mark ? 1 : col_pos + 1;
        if (col_pos >= cur_len)
            col_pos = 0;
    endtask

    // Raster stream: the column's coefficient, now and then a stray one.
    task automatic stream_cell(input logic signed [VALUE_BITS-1:0] value);
        logic                 mark;
        logic [COEF_BITS-1:0] coef;
        mark = sweep_due || ($urandom_range(63) == 0);
        if (mark)
            col_pos = 0;
        coef = column_coef[col_pos];
        if ($urandom_range(31) == 0)
            coef = COEF_BITS'($urandom);
        send_cell(value, coef, mark);
    endtask

    // Stop sending and wait until every result word has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] draw_value();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3, 4:    return VALUE_BITS'($signed($urandom_range(1023)) - 512);
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    // New coefficient per column; zero where the wind is below roughness.
    task automatic fill_column_coefs();
        for (int c = 0; c < cur_len; c++) begin
            case ($urandom_range(15))
                0, 1:    column_coef[c] = '0;
                2:       column_coef[c] = '1;
                3, 4, 5: column_coef[c] = COEF_BITS'($urandom_range(2047));
                default: column_coef[c] = COEF_BITS'($urandom);
            endcase
        end
    endtask

    initial begin
        logic [COEF_BITS-1:0]         y_pick;
        logic [LEN_BITS-1:0]          cols_pick;
        logic signed [VALUE_BITS-1:0] bnd_pick;
        int                           n_items;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        cell_value     = '0;
        x_coef         = '0;
        start_of_sweep = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: full rows, zero boundary, no y flow.
        send_cell(16'sd1000, 16'd0, 1'b0);
        send_cell(-16'sd1000, 16'hFFFF, 1'b0);
        send_cell(16'sh7FFF, 16'd12345, 1'b0);
        wait_for_results();

        // Shrink to three columns while past the end of the new row, then
        // drive hard against the most negative boundary.
        program_grid(16'hFFFF, 11'd3, 16'sh8000);
        send_cell(16'sh7FFF, 16'hFFFF, 1'b0);
        send_cell(16'sh7FFF, 16'hFFFF, 1'b1);
        send_cell(16'sh8000, 16'd0, 1'b0);
        send_cell(16'sd0, 16'hFFFF, 1'b0);
        send_cell(16'sh8000, 16'hFFFF, 1'b0);
        send_cell(16'sh7FFF, 16'hFFFF, 1'b0);
        send_cell(16'sd12345, 16'h8000, 1'b0);
        send_cell(16'sd7, 16'd1, 1'b0);
        send_cell(-16'sd1, 16'd0, 1'b1);
        wait_for_results();

        // Row length of zero behaves as one column.
        program_grid(16'd0, 11'd0, 16'sh7FFF);
        send_cell(16'sh8000, 16'hFFFF, 1'b1);
        send_cell(16'sh8000, 16'hFFFF, 1'b0);
        send_cell(16'sh7FFF, 16'hFFFF, 1'b0);
        wait_for_results();

        // Oversize row length; growth starts a fresh sweep.
        program_grid(16'h8000, 11'd2047, 16'sd0);
        send_cell(16'sd5000, 16'd1000, 1'b1);
        send_cell(-16'sd5000, 16'd60000, 1'b0);
        send_cell(16'sh7FFF, 16'hFFFF, 1'b0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // Receiver stalls heavily and sender idles lightly first, then the reverse, then neither.
            if (p < NUM_PHASES / 3) begin
                send_gap_pct = 6;
                stall_pct    = 70;
            end
            else if (p < 2 * NUM_PHASES / 3) begin
                send_gap_pct = 70;
                stall_pct    = 6;
            end
            else begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end
            wait_for_results();

            case (p % 4)
                0:       y_pick = '0;
                1:       y_pick = '1;
                2:       y_pick = COEF_BITS'($urandom_range(4096));
                default: y_pick = COEF_BITS'($urandom);
            endcase
            case (p % 5)
                0:       bnd_pick = 16'sh8000;
                1:       bnd_pick = 16'sh7FFF;
                2:       bnd_pick = '0;
                default: bnd_pick = VALUE_BITS'($urandom);
            endcase
            n_items = $urandom_range(30, 52);
            case (p % 6)
                0:       cols_pick = 11'd1;
                1:       cols_pick = 11'd2;
                2:       cols_pick = LEN_BITS'($urandom_range(3, 8));
                3:       cols_pick = LEN_BITS'($urandom_range(9, 40));
                4:       cols_pick = LEN_BITS'($urandom_range(2, 16));
                default: cols_pick = LEN_BITS'($urandom_range(41, 128));
            endcase
            if (p == 3)
                cols_pick = '0;
            if (p == 21)
                cols_pick = LEN_BITS'(MAX_COLS);
            // One phase runs at the oversize row length.
            if (p == 13)
                cols_pick = '1;

            program_grid(y_pick, cols_pick, bnd_pick);
            fill_column_coefs();
            for (int i = 0; i < n_items; i++) begin
                if (p % 4 == 1 && i == n_items / 2)
                    wait_for_results();
                stream_cell(draw_value());
            end
        end

        wait_for_results();
        repeat (8) @(posedge clk);
        $display("Covered %0d cells over %0d register settings, row lengths 0 to 2047;",
                 cells_sent, settings_cnt);
        $display("%0d result words compared, %0d of them saturated.", checked, saturated);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### upwind_advection_step.f
hw/rtl/uas_pkg.sv
hw/rtl/uas_regs.sv
hw/rtl/upwind_advection_step.sv
tb/sv/upwind_step_checker.sv
tb/sv/upwind_advection_step_tb.sv
